@@ rtl/core/b64_pkg.sv @@
// Shared types, codes and the alphabet lookup for the Base64 stream encoder.
// Depends on nothing; every module of the encoder imports it.
package b64_pkg;

    localparam logic [7:0] PAD_CHAR = 8'h3D;  // '='

    // Configuration register indexes
    localparam logic [0:0] CFG_URL_ALPHABET = 1'd0;
    localparam logic [0:0] CFG_ADD_PADDING  = 1'd1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_b64_in;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_char;
    } t_b64_out;

    // One group of characters, as the front hands it to the back
    typedef struct packed {
        logic [3:0][5:0] sextet;
        logic [2:0]      n_data;   // alphabet characters, 2..4
        logic [2:0]      n_chars;  // data plus padding characters, 2..4
        logic            last;
    } t_b64_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_b64_qstat;

    typedef enum logic [1:0] {
        PH_EMPTY,
        PH_ONE,
        PH_TWO
    } t_b64_phase;

    function automatic logic [7:0] map_sextet(input logic [5:0] v, input logic url);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            c = 8'h61 + {2'b00, v} - 8'd26;
        end else if (v < 6'd62) begin
            c = 8'h30 + {2'b00, v} - 8'd52;
        end else if (v == 6'd62) begin
            c = url ? 8'h2D : 8'h2B;
        end else begin
            c = url ? 8'h5F : 8'h2F;
        end
        return c;
    endfunction

endpackage

@@ rtl/core/base64_stream_encoder.sv @@
// Base64 stream encoder: one byte in per transaction, one character out.
// A closing byte's command goes into the queue, then the back's command register,
// then the single-character output register, which caps throughput at one
// character per cycle while groups wait and the receiver is ready.
// Reset: synchronous, active low; empties group, queue and output register,
// and sets url_alphabet to 0 and add_padding to 1.
module base64_stream_encoder
    import b64_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_b64_in  i_in,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_b64_out o_out,
    input  logic     i_cfg_we,
    input  logic     i_cfg_index,
    input  logic     i_cfg_data
);

    localparam int CMD_W = $bits(t_b64_cmd);

    // Configuration registers; the user must write them only while the block is idle (not enforced here)
    logic r_url_alphabet, n_url_alphabet;
    logic r_add_padding, n_add_padding;

    always_comb begin
        n_url_alphabet = r_url_alphabet;
        n_add_padding  = r_add_padding;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_URL_ALPHABET: n_url_alphabet = i_cfg_data;
                CFG_ADD_PADDING:  n_add_padding  = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_url_alphabet <= 1'b0;
            r_add_padding  <= 1'b1;
        end else begin
            r_url_alphabet <= n_url_alphabet;
            r_add_padding  <= n_add_padding;
        end
    end

    logic             in_accept;
    logic             push;
    logic             pop;
    t_b64_cmd         front_cmd;
    t_b64_cmd         head_cmd;
    logic [CMD_W-1:0] head_bits;
    t_b64_qstat       qstat;

    // Hold off bytes while the queue has no room for a group; a byte that
    // only gets stored is held off too, which keeps the front simple.
    assign o_in_ready = !qstat.full;
    assign in_accept  = i_in_valid && o_in_ready;

    b64_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_in          (i_in),
        .i_add_padding (r_add_padding),
        .o_push        (push),
        .o_cmd         (front_cmd)
    );

    b64_queue #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .i_pop   (pop),
        .o_data  (head_bits),
        .o_stat  (qstat)
    );

    assign head_cmd = t_b64_cmd'(head_bits);

    b64_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_qstat        (qstat),
        .i_cmd          (head_cmd),
        .o_pop          (pop),
        .i_url_alphabet (r_url_alphabet),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out          (o_out)
    );

`ifndef SYNTH
    // A marked byte always closes a group and yields a command
    a_last_pushes : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in.last_byte) |-> push)
        else $error("marked byte did not produce a group");

    // The front never pushes into a full queue
    a_no_overflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !qstat.full)
        else $error("group pushed into full queue");

    // The back never pops an empty queue
    a_no_underflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !qstat.empty)
        else $error("pop from empty queue");

    // After a pop the queue is never full
    a_pop_drains : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> !qstat.full)
        else $error("queue still full after a pop");
`endif

endmodule

@@ rtl/core/b64_front.sv @@
// Front of the Base64 encoder: takes bytes, gathers groups, builds commands.
// Depends on b64_pkg.
module b64_front
    import b64_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  t_b64_in    i_in,
    input  logic       i_add_padding,
    output logic       o_push,
    output t_b64_cmd   o_cmd
);

    t_b64_phase r_phase, n_phase;
    logic [7:0] r_pend0, n_pend0;
    logic [7:0] r_pend1, n_pend1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_EMPTY;
        end else begin
            r_phase <= n_phase;
        end
        r_pend0 <= n_pend0;
        r_pend1 <= n_pend1;
    end

    always_comb begin
        logic [7:0] b;
        b       = i_in.data_byte;
        n_phase = r_phase;
        n_pend0 = r_pend0;
        n_pend1 = r_pend1;
        o_push  = 1'b0;
        o_cmd   = '0;
        o_cmd.last = i_in.last_byte;
        unique case (r_phase)
            PH_TWO: begin
                o_cmd.sextet[0] = r_pend0[7:2];
                o_cmd.sextet[1] = {r_pend0[1:0], r_pend1[7:4]};
                o_cmd.sextet[2] = {r_pend1[3:0], b[7:6]};
                o_cmd.sextet[3] = b[5:0];
                o_cmd.n_data    = 3'd4;
                o_cmd.n_chars   = 3'd4;
                if (i_accept) begin
                    o_push  = 1'b1;
                    n_phase = PH_EMPTY;
                end
            end
            PH_ONE: begin
                o_cmd.sextet[0] = r_pend0[7:2];
                o_cmd.sextet[1] = {r_pend0[1:0], b[7:4]};
                o_cmd.sextet[2] = {b[3:0], 2'b00};
                o_cmd.n_data    = 3'd3;
                o_cmd.n_chars   = i_add_padding ? 3'd4 : 3'd3;
                if (i_accept) begin
                    if (i_in.last_byte) begin
                        o_push  = 1'b1;
                        n_phase = PH_EMPTY;
                    end else begin
                        n_pend1 = b;
                        n_phase = PH_TWO;
                    end
                end
            end
            default: begin
                // empty group; the unused code also lands here
                o_cmd.sextet[0] = b[7:2];
                o_cmd.sextet[1] = {b[1:0], 4'b0000};
                o_cmd.n_data    = 3'd2;
                o_cmd.n_chars   = i_add_padding ? 3'd4 : 3'd2;
                if (i_accept) begin
                    if (i_in.last_byte) begin
                        o_push  = 1'b1;
                        n_phase = PH_EMPTY;
                    end else begin
                        n_pend0 = b;
                        n_phase = PH_ONE;
                    end
                end
            end
        endcase
    end

endmodule

@@ rtl/core/b64_queue.sv @@
// Short register queue between the front and the back of the encoder.
// Depends on b64_pkg for the status struct.
module b64_queue
    import b64_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output t_b64_qstat       o_stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, n_wr;
    logic [AW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_count, n_count;
    logic             push_ok, pop_ok;

    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign push_ok      = i_push && !o_stat.full;
    assign pop_ok       = i_pop && !o_stat.empty;
    assign o_data       = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (push_ok) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (pop_ok) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        if (push_ok && !pop_ok) begin
            n_count = r_count + CW'(1);
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
        if (push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

@@ rtl/core/b64_back.sv @@
// Back of the Base64 encoder: walks one command a character at a time
// into the output register. Depends on b64_pkg.
module b64_back
    import b64_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_b64_qstat i_qstat,
    input  t_b64_cmd   i_cmd,
    output logic       o_pop,
    input  logic       i_url_alphabet,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_b64_out   o_out
);

    logic     r_busy, n_busy;
    t_b64_cmd r_cmd, n_cmd;
    logic [1:0] r_idx, n_idx;
    logic     r_out_valid, n_out_valid;
    t_b64_out r_out, n_out;
    logic     advance, at_end;

    assign advance = r_busy && (!r_out_valid || i_out_ready);
    assign at_end  = ({1'b0, r_idx} == (r_cmd.n_chars - 3'd1));
    assign o_pop   = !i_qstat.empty && (!r_busy || (advance && at_end));

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        n_busy      = r_busy;
        n_cmd       = r_cmd;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (advance) begin
            n_out_valid = 1'b1;
            if ({1'b0, r_idx} < r_cmd.n_data) begin
                n_out.out_char = map_sextet(r_cmd.sextet[r_idx], i_url_alphabet);
            end else begin
                n_out.out_char = PAD_CHAR;
            end
            n_out.last_char = r_cmd.last && at_end;
            if (at_end) begin
                n_busy = 1'b0;
            end else begin
                n_idx = r_idx + 2'd1;
            end
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        // load the next group when idle or as the current one finishes
        if (o_pop) begin
            n_busy = 1'b1;
            n_cmd  = i_cmd;
            n_idx  = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
        r_cmd <= n_cmd;
        r_idx <= n_idx;
        r_out <= n_out;
    end

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for base64_stream_encoder: directed table, receiver hold-off, then random messages.
// Depends on b64_pkg for the payload types, the pad character and the register indexes.
module tb
    import b64_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          SETTLE_CYCLES = 6;       // output latency plus margin
    localparam int          HOLD_CYCLES   = 300;     // long receiver hold-off
    localparam int          ITEMS_PER_RUN = 112;     // minimum random bytes per idling pattern
    localparam int unsigned CYCLE_LIMIT   = 200000;  // several times the slowest correct run
    localparam int          MAX_REPORTS   = 100;

    localparam logic [8*64-1:0] STD_ALPHA =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    localparam logic [8*64-1:0] URL_ALPHA =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

    // One directed byte. When 'fixed' is set, n_chars and chars give the expected
    // characters, first character in the most significant byte that is used.
    typedef struct packed {
        logic        url;
        logic        pad;
        logic [7:0]  data;
        logic        last;
        logic        fixed;
        logic [2:0]  n_chars;
        logic [31:0] chars;
    } t_dir_row;

    localparam int DIR_ROWS = 25;
    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        // after reset: standard alphabet, padding on; lone byte extremes
        '{1'b0, 1'b1, 8'h00, 1'b1, 1'b1, 3'd4, "AA=="},
        '{1'b0, 1'b1, 8'hFF, 1'b1, 1'b1, 3'd4, "/w=="},
        // full group of ones, marked on the byte that completes it
        '{1'b0, 1'b1, 8'hFF, 1'b0, 1'b1, 3'd0, 32'h0},
        '{1'b0, 1'b1, 8'hFF, 1'b0, 1'b1, 3'd0, 32'h0},
        '{1'b0, 1'b1, 8'hFF, 1'b1, 1'b1, 3'd4, "////"},
        // same under the URL-safe alphabet, then a lone byte
        '{1'b1, 1'b1, 8'hFF, 1'b0, 1'b1, 3'd0, 32'h0},
        '{1'b1, 1'b1, 8'hFF, 1'b0, 1'b1, 3'd0, 32'h0},
        '{1'b1, 1'b1, 8'hFF, 1'b1, 1'b1, 3'd4, "____"},
        '{1'b1, 1'b1, 8'hFF, 1'b1, 1'b1, 3'd4, "_w=="},
        // padding off: lone byte gives two characters, byte pair three
        '{1'b1, 1'b0, 8'h00, 1'b1, 1'b1, 3'd2, "AA"},
        '{1'b1, 1'b0, 8'hFB, 1'b0, 1'b0, 3'd0, 32'h0},
        '{1'b1, 1'b0, 8'hEF, 1'b1, 1'b0, 3'd0, 32'h0},
        '{1'b0, 1'b0, 8'hFB, 1'b0, 1'b0, 3'd0, 32'h0},
        '{1'b0, 1'b0, 8'hEF, 1'b1, 1'b0, 3'd0, 32'h0},
        // padding on: byte pair, then an unmarked full group
        '{1'b0, 1'b1, 8'h00, 1'b0, 1'b1, 3'd0, 32'h0},
        '{1'b0, 1'b1, 8'h00, 1'b1, 1'b1, 3'd4, "AAA="},
        '{1'b0, 1'b1, 8'h00, 1'b0, 1'b1, 3'd0, 32'h0},
        '{1'b0, 1'b1, 8'h00, 1'b0, 1'b1, 3'd0, 32'h0},
        '{1'b0, 1'b1, 8'h00, 1'b0, 1'b1, 3'd4, "AAAA"},
        // the textbook triple closes that message
        '{1'b0, 1'b1, 8'h4D, 1'b0, 1'b1, 3'd0, 32'h0},
        '{1'b0, 1'b1, 8'h61, 1'b0, 1'b1, 3'd0, 32'h0},
        '{1'b0, 1'b1, 8'h6E, 1'b1, 1'b1, 3'd4, "TWFu"},
        // padding off, alternating nibbles
        '{1'b0, 1'b0, 8'hF0, 1'b1, 1'b0, 3'd0, 32'h0},
        '{1'b0, 1'b0, 8'h0F, 1'b0, 1'b0, 3'd0, 32'h0},
        '{1'b0, 1'b0, 8'hF0, 1'b1, 1'b0, 3'd0, 32'h0}
    };

    // Clock, reset and every DUT input start at a known value.
    logic     i_clk     = 1'b0;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    t_b64_in  in_item   = '0;
    logic     out_ready = 1'b0;
    logic     cfg_we    = 1'b0;
    logic     cfg_index = CFG_URL_ALPHABET;
    logic     cfg_data  = 1'b0;
    logic     in_ready;
    logic     out_valid;
    t_b64_out out_item;

    // Idling percentages and the hold-off request
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic hold_trigger  = 1'b0;
    logic hold_active   = 1'b0;

    int          mismatch_count = 0;
    int unsigned cycle_count    = 0;

    // Encoder shadow: register copies, group position and held bytes
    logic       pred_url   = 1'b0;
    logic       pred_pad   = 1'b1;
    t_b64_phase pred_phase = PH_EMPTY;
    logic [7:0] pred_held [2];

    // Characters still owed by the DUT, oldest first
    t_b64_out enc_char_q [$];

    base64_stream_encoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Abort a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_REPORTS) begin
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        end
        mismatch_count++;
    endtask

    function automatic logic [7:0] sextet_to_ascii(input logic [5:0] v);
        int pos;
        pos = 8 * (63 - int'(v));
        return pred_url ? URL_ALPHA[pos +: 8] : STD_ALPHA[pos +: 8];
    endfunction

    // Advance the shadow by one accepted byte; queue the characters it yields
    // unless the caller supplies its own expectation.
    function automatic void encode_byte(input t_b64_in it, input bit keep);
        logic [5:0] sx [4];
        logic [7:0] b;
        logic [7:0] b0;
        logic [7:0] b1;
        int         n_data;
        int         n_all;
        int         k;
        t_b64_out   ch;
        b      = it.data_byte;
        b0     = pred_held[0];
        b1     = pred_held[1];
        n_data = 0;
        n_all  = 0;
        for (k = 0; k < 4; k++) begin
            sx[k] = '0;
        end
        if (pred_phase == PH_TWO) begin
            // third byte closes the group, marked or not
            sx[0]      = b0[7:2];
            sx[1]      = {b0[1:0], b1[7:4]};
            sx[2]      = {b1[3:0], b[7:6]};
            sx[3]      = b[5:0];
            n_data     = 4;
            n_all      = 4;
            pred_phase = PH_EMPTY;
        end else if (!it.last_byte) begin
            // hold the byte, nothing comes out
            if (pred_phase == PH_ONE) begin
                pred_held[1] = b;
                pred_phase   = PH_TWO;
            end else begin
                pred_held[0] = b;
                pred_phase   = PH_ONE;
            end
        end else if (pred_phase == PH_ONE) begin
            sx[0]      = b0[7:2];
            sx[1]      = {b0[1:0], b[7:4]};
            sx[2]      = {b[3:0], 2'b00};
            n_data     = 3;
            n_all      = pred_pad ? 4 : 3;
            pred_phase = PH_EMPTY;
        end else begin
            // lone marked byte; any other phase code counts as empty
            sx[0]      = b[7:2];
            sx[1]      = {b[1:0], 4'b0000};
            n_data     = 2;
            n_all      = pred_pad ? 4 : 2;
            pred_phase = PH_EMPTY;
        end
        if (keep) begin
            for (k = 0; k < n_all; k++) begin
                ch.out_char  = (k < n_data) ? sextet_to_ascii(sx[k]) : PAD_CHAR;
                ch.last_char = it.last_byte && (k == n_all - 1);
                enc_char_q.push_back(ch);
            end
        end
    endfunction

    // Offer one byte, idling before it at the sender's rate, and hold it until
    // the transaction completes. Called at a rising edge.
    task automatic push_byte(input logic [7:0] data, input logic last, input bit fixed,
                             input int n_fixed, input logic [31:0] fixed_chars);
        t_b64_in  it;
        t_b64_out ch;
        int       k;
        it.data_byte = data;
        it.last_byte = last;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do begin
            @(posedge i_clk);
        end while (!in_ready);
        // accepted at this edge
        encode_byte(it, !fixed);
        if (fixed) begin
            for (k = 0; k < n_fixed; k++) begin
                ch.out_char  = fixed_chars[8 * (n_fixed - 1 - k) +: 8];
                ch.last_char = last && (k == n_fixed - 1);
                enc_char_q.push_back(ch);
            end
        end
    endtask

    // Drop valid and wait until every owed character has arrived and the
    // pipeline has had time to settle.
    task automatic drain_output();
        in_valid <= 1'b0;
        while (enc_char_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both registers on back-to-back edges; only call while drained.
    task automatic set_config(input logic url, input logic pad);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_URL_ALPHABET;
        cfg_data  <= url;
        @(posedge i_clk);
        pred_url  = url;
        cfg_index <= CFG_ADD_PADDING;
        cfg_data  <= pad;
        @(posedge i_clk);
        pred_pad  = pad;
        cfg_we    <= 1'b0;
    endtask

    // Random messages under one idling pattern. Now and then, stop inside a
    // message, drain and change the registers, so the held bytes meet a new setting.
    task automatic random_run(input int s_pct, input int r_pct, input bit rand_cfg,
                              input logic url, input logic pad);
        int sent;
        int len;
        int i;
        drain_output();
        send_idle_pct = s_pct;
        recv_idle_pct <= r_pct;
        if (rand_cfg) begin
            set_config(1'($urandom_range(1)), 1'($urandom_range(1)));
        end else begin
            set_config(url, pad);
        end
        sent = 0;
        while (sent < ITEMS_PER_RUN) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 8);
            for (i = 0; i < len; i++) begin
                if (i > 0 && $urandom_range(39) == 0) begin
                    drain_output();
                    set_config(1'($urandom_range(1)), 1'($urandom_range(1)));
                end
                push_byte(8'($urandom_range(255)), i == len - 1, 1'b0, 0, 32'h0);
            end
            sent += len;
        end
    endtask

    // Receiver: check each accepted character, then pick the next ready.
    always @(posedge i_clk) begin
        t_b64_out want;
        if (rst_n && out_valid && out_ready) begin
            if (enc_char_q.size() == 0) begin
                report_mismatch($sformatf("unexpected char 0x%02h last=%0b",
                                          out_item.out_char, out_item.last_char));
            end else begin
                want = enc_char_q.pop_front();
                if (out_item.out_char !== want.out_char) begin
                    report_mismatch($sformatf("out_char 0x%02h, expected 0x%02h",
                                              out_item.out_char, want.out_char));
                end
                if (out_item.last_char !== want.last_char) begin
                    report_mismatch($sformatf("last_char %0b, expected %0b on char 0x%02h",
                                              out_item.last_char, want.last_char,
                                              want.out_char));
                end
            end
        end
        if (hold_active) begin
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Hold the receiver off for a long stretch once requested.
    initial begin : hold_off
        wait (hold_trigger);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_active <= 1'b0;
    end

    initial begin : stimulus
        int r;
        int i;
        t_dir_row row;

        repeat (7) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table; change registers only between drained rows.
        recv_idle_pct <= 30;
        for (r = 0; r < DIR_ROWS; r++) begin
            row = DIR_TABLE[r];
            if (row.url != pred_url || row.pad != pred_pad) begin
                drain_output();
                set_config(row.url, row.pad);
            end
            push_byte(row.data, row.last, row.fixed, int'(row.n_chars), row.chars);
        end
        drain_output();

        // Backpressure: stall the receiver while the sender keeps offering,
        // then pause the sender until every character is out.
        recv_idle_pct <= 0;
        hold_trigger  <= 1'b1;
        for (i = 0; i < 48; i++) begin
            push_byte(8'($urandom_range(255)), i == 47, 1'b0, 0, 32'h0);
        end
        drain_output();

        random_run(19, 70, 1'b0, 1'b1, 1'b0);
        random_run(70, 19, 1'b0, 1'b0, 1'b1);
        random_run(0, 0, 1'b1, 1'b0, 1'b0);

        drain_output();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/b64_pkg.sv
rtl/core/b64_front.sv
rtl/core/b64_queue.sv
rtl/core/b64_back.sv
rtl/core/base64_stream_encoder.sv
tb/sv/tb.sv
